>>> src/fat12_pkg.sv
// Shared types, codes and helpers for the FAT12 table engine.
`timescale 1ns / 1ps

package fat12_pkg;

	localparam int BYTE_ADDR_W = 13;
	localparam int CLUSTER_W   = 12;
	localparam int COUNT_W     = 13;

	localparam logic [11:0] END_MARK    = 12'hff8;
	localparam logic [11:0] ENTRY_MASK  = 12'hfff;
	localparam logic [7:0]  LOW_NIBBLE  = 8'h0f;
	localparam logic [7:0]  HIGH_NIBBLE = 8'hf0;

	localparam logic [2:0] OP_WRITE_BYTE  = 3'd0;
	localparam logic [2:0] OP_READ_BYTE   = 3'd1;
	localparam logic [2:0] OP_READ_ENTRY  = 3'd2;
	localparam logic [2:0] OP_WRITE_ENTRY = 3'd3;
	localparam logic [2:0] OP_FREE_CHAIN  = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [12:0] byte_addr;
		logic [7:0]  byte_data;
		logic [11:0] cluster;
		logic [11:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [11:0] read_value;
		logic [12:0] freed_count;
		logic        error;
	} rsp_t;

	typedef enum logic [2:0] {
		K_NOTHING,
		K_BYTE_WR,
		K_BYTE_RD,
		K_ENT_RD,
		K_ENT_WR,
		K_FREE
	} kind_t;

	// Classified command between front and back
	typedef struct packed {
		kind_t       kind;
		logic [12:0] addr;
		logic [7:0]  data;
		logic [11:0] cluster;
		logic [11:0] value;
		logic [11:0] rv;
		logic        err;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LINK,
		ST_READ_LO,
		ST_READ_HI,
		ST_READ_END,
		ST_WRITE_LO,
		ST_WRITE_HI,
		ST_REPLY
	} back_state_t;

	// Byte offset of a cluster's entry: 3 * (c / 2) + (c % 2)
	function automatic logic [12:0] entry_base(input logic [11:0] c);
		logic [12:0] half;
		half = {2'b00, c[11:1]};
		return (half << 1) + half + {12'd0, c[0]};
	endfunction

	function automatic logic entry_in_range(input logic [11:0] c, input logic [13:0] max_cl,
			input logic [13:0] tbl_bytes);
		logic [13:0] hi_byte;
		hi_byte = {1'b0, entry_base(c)} + 14'd1;
		return ({2'b00, c} < max_cl) && (hi_byte < tbl_bytes);
	endfunction

endpackage

>>> src/fat12_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fat12_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 6144,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/fat12_front.sv
// Front end: takes request beats, checks ranges and classifies them into commands.
`timescale 1ns / 1ps

module fat12_front import fat12_pkg::*; #(
	parameter int TABLE_BYTES  = 6144,
	parameter int MAX_CLUSTERS = 4096
) (
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	input  logic full,
	output logic push,
	output cmd_t cmd
);

	logic byte_ok;
	logic entry_ok;

	assign byte_ok  = {1'b0, req.byte_addr} < 14'(TABLE_BYTES);
	assign entry_ok = entry_in_range(req.cluster, 14'(MAX_CLUSTERS), 14'(TABLE_BYTES));

	assign req_stall = full;
	assign push      = req_valid && !full;

	always_comb begin
		cmd.kind    = K_NOTHING;
		cmd.addr    = req.byte_addr;
		cmd.data    = req.byte_data;
		cmd.cluster = req.cluster;
		cmd.value   = req.entry_value;
		cmd.rv      = '0;
		cmd.err     = 1'b0;
		unique case (req.operation)
			OP_WRITE_BYTE: begin
				cmd.kind = byte_ok ? K_BYTE_WR : K_NOTHING;
				cmd.err  = !byte_ok;
			end
			OP_READ_BYTE: begin
				cmd.kind = byte_ok ? K_BYTE_RD : K_NOTHING;
				cmd.err  = !byte_ok;
			end
			OP_READ_ENTRY: begin
				cmd.addr = entry_base(req.cluster);
				// cluster zero answers with the end mark without a table access
				if (req.cluster == '0) begin
					cmd.rv = END_MARK;
				end else if (entry_ok) begin
					cmd.kind = K_ENT_RD;
				end else begin
					cmd.err = 1'b1;
				end
			end
			OP_WRITE_ENTRY: begin
				cmd.addr = entry_base(req.cluster);
				cmd.kind = entry_ok ? K_ENT_WR : K_NOTHING;
				cmd.err  = !entry_ok;
			end
			OP_FREE_CHAIN: begin
				cmd.kind = K_FREE;
			end
			default: begin
				cmd.kind = K_NOTHING;
			end
		endcase
	end

endmodule

>>> src/fat12_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module fat12_queue import fat12_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> src/fat12_back.sv
// Back end: sequences table memory accesses for each command and holds the response beat.
`timescale 1ns / 1ps

module fat12_back import fat12_pkg::*; #(
	parameter int TABLE_BYTES  = 6144,
	parameter int MAX_CLUSTERS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  cmd_t        head,
	output logic        pop,
	input  logic [11:0] free_mark,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp
);

	localparam int AW = $clog2(TABLE_BYTES);

	back_state_t state_q, state_d;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	kind_t       kind_q;
	logic [12:0] addr_q;
	logic        odd_q;
	logic [7:0]  byte_q;
	logic [11:0] cur_q;
	logic [11:0] val_q;
	logic [7:0]  lo_q;
	logic [7:0]  hi_q;
	logic [11:0] rv_q;
	logic        err_q;
	logic [12:0] cnt_q;

	logic          rsp_free;
	logic          link_end;
	logic          link_bad;
	logic [12:0]   addr_hi;
	logic [11:0]   entry_val;
	logic [7:0]    new_lo;
	logic [7:0]    new_hi;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign link_end  = (cur_q == '0) || ((cur_q & END_MARK) == END_MARK);
	assign link_bad  = (cnt_q >= 13'(MAX_CLUSTERS))
		|| !entry_in_range(cur_q, 14'(MAX_CLUSTERS), 14'(TABLE_BYTES));
	assign addr_hi   = addr_q + 13'd1;
	assign entry_val = odd_q ? {rd_data, lo_q[7:4]} : {rd_data[3:0], lo_q};
	// merge the new value with the nibble shared with the neighbor entry
	assign new_lo    = odd_q ? ((lo_q & LOW_NIBBLE) | ({val_q[3:0], 4'b0000} & HIGH_NIBBLE))
		: val_q[7:0];
	assign new_hi    = odd_q ? val_q[11:4]
		: ((hi_q & HIGH_NIBBLE) | ({4'b0000, val_q[11:8]} & LOW_NIBBLE));

	fat12_ram #(
		.WIDTH(8),
		.DEPTH(TABLE_BYTES)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					unique case (head.kind)
						K_NOTHING: state_d = ST_REPLY;
						K_BYTE_WR: state_d = ST_WRITE_LO;
						K_FREE:    state_d = ST_LINK;
						K_BYTE_RD, K_ENT_RD, K_ENT_WR: state_d = ST_READ_LO;
						default:   state_d = ST_REPLY;
					endcase
				end
			end
			ST_LINK:     state_d = (link_end || link_bad) ? ST_REPLY : ST_READ_LO;
			ST_READ_LO:  state_d = ST_READ_HI;
			ST_READ_HI:  state_d = (kind_q == K_BYTE_RD) ? ST_REPLY : ST_READ_END;
			ST_READ_END: state_d = (kind_q == K_ENT_RD) ? ST_REPLY : ST_WRITE_LO;
			ST_WRITE_LO: state_d = (kind_q == K_BYTE_WR) ? ST_REPLY : ST_WRITE_HI;
			ST_WRITE_HI: state_d = (kind_q == K_FREE) ? ST_LINK : ST_REPLY;
			ST_REPLY: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		wr_en   = 1'b0;
		wr_addr = addr_q[AW-1:0];
		wr_data = new_lo;
		rd_addr = addr_q[AW-1:0];
		unique case (state_q)
			ST_IDLE:     pop = !empty;
			ST_READ_HI:  rd_addr = addr_hi[AW-1:0];
			ST_WRITE_LO: begin
				wr_en   = 1'b1;
				wr_data = (kind_q == K_BYTE_WR) ? byte_q : new_lo;
			end
			ST_WRITE_HI: begin
				wr_en   = 1'b1;
				wr_addr = addr_hi[AW-1:0];
				wr_data = new_hi;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_REPLY && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					kind_q <= head.kind;
					addr_q <= head.addr;
					odd_q  <= head.cluster[0];
					byte_q <= head.data;
					cur_q  <= head.cluster;
					val_q  <= (head.kind == K_FREE) ? free_mark : head.value;
					rv_q   <= head.rv;
					err_q  <= head.err;
					cnt_q  <= '0;
				end
			end
			ST_LINK: begin
				addr_q <= entry_base(cur_q);
				odd_q  <= cur_q[0];
				if (!link_end && link_bad) begin
					err_q <= 1'b1;
				end
			end
			ST_READ_HI: begin
				lo_q <= rd_data;
				if (kind_q == K_BYTE_RD) begin
					rv_q <= {4'b0000, rd_data};
				end
			end
			ST_READ_END: begin
				hi_q  <= rd_data;
				cur_q <= entry_val;
				if (kind_q == K_ENT_RD) begin
					rv_q <= entry_val & ENTRY_MASK;
				end
			end
			ST_WRITE_HI: begin
				if (kind_q == K_FREE) begin
					cnt_q <= cnt_q + 13'd1;
				end
			end
			ST_REPLY: begin
				if (rsp_free) begin
					rsp_q.read_value  <= rv_q;
					rsp_q.freed_count <= cnt_q;
					rsp_q.error       <= err_q;
				end
			end
			default: begin
				kind_q <= kind_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> src/fat12_table_engine.sv
// FAT12 allocation table engine. The table lives in one byte-wide RAM, two 12-bit entries
// packed into every three bytes. A request beat is checked and classified at once and parked
// in a two-entry queue, so requests are still taken while a response beat waits on rsp_stall,
// until the queue is full. The back end works one command at a time through the RAM, whose
// read is registered; freeing a chain does two reads and two writes per link. free_mark
// is written through free_mark_we/free_mark_data and resets to 0; writing it only while the
// engine is idle is up to the user, since the block itself does not enforce it.
// The table has no reset; reading bytes never written returns undefined data.
`timescale 1ns / 1ps

module fat12_table_engine import fat12_pkg::*; #(
	parameter int TABLE_BYTES  = 6144,
	parameter int MAX_CLUSTERS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        free_mark_we,
	input  logic [11:0] free_mark_data
);

	logic [11:0] free_mark_q;
	logic        push;
	cmd_t        push_cmd;
	logic        full;
	logic        pop;
	logic        empty;
	cmd_t        head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_mark_q <= '0;
		end else if (free_mark_we) begin
			free_mark_q <= free_mark_data;
		end
	end

	fat12_front #(
		.TABLE_BYTES (TABLE_BYTES),
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_front (
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.full     (full),
		.push     (push),
		.cmd      (push_cmd)
	);

	fat12_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	fat12_back #(
		.TABLE_BYTES (TABLE_BYTES),
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.free_mark(free_mark_q),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

>>> src/fat12_checker.sv
// Port-level checks for the FAT12 table engine, bound to the top level.
`timescale 1ns / 1ps

module fat12_checker import fat12_pkg::*; #(
	parameter int MAX_CLUSTERS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	a_free_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.freed_count != '0) |-> rsp.read_value == '0)
		else $error("freed chain reported a read value");

	a_error_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error |-> rsp.read_value == '0)
		else $error("error response carried a read value");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.freed_count <= 13'(MAX_CLUSTERS))
		else $error("freed count beyond cluster bound");

	// leaving reset the engine is empty: no stall, no response
	a_idle_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !req_stall && !rsp_valid)
		else $error("engine not idle after reset");

endmodule

bind fat12_table_engine fat12_checker #(
	.MAX_CLUSTERS(MAX_CLUSTERS)
) u_fat12_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

>>> verif/fat12_table_checker.sv
// Scoreboard for the FAT12 table engine: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module fat12_table_checker import fat12_pkg::*; #(
	parameter int TABLE_BYTES  = 6144,
	parameter int MAX_CLUSTERS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	input  logic        free_mark_we,
	input  logic [11:0] free_mark_data,
	output int          mismatches,
	output int          outstanding
);

	logic [7:0]  table_copy [TABLE_BYTES];
	logic [11:0] mark_value = '0;
	rsp_t        due_responses [$];
	rsp_t        oldest;
	int          fail_count = 0;
	int          waiting = 0;

	assign mismatches  = fail_count;
	assign outstanding = waiting;

	task automatic report_mismatch(input string what, input logic [12:0] got,
			input logic [12:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Three bytes per cluster pair; odd clusters start one byte in
	function automatic bit locate_entry(input logic [11:0] c, output int unsigned off);
		if (c >= MAX_CLUSTERS)
			return 1'b0;
		off = 3 * (c >> 1) + c[0];
		return (off + 1) < TABLE_BYTES;
	endfunction

	function automatic logic [11:0] fetch_entry(input logic [11:0] c, input int unsigned off);
		logic [15:0] pair;
		pair = {table_copy[off + 1], table_copy[off]};
		return c[0] ? pair[15:4] : pair[11:0];
	endfunction

	// Keep the nibble that belongs to the neighbor entry
	function automatic void store_entry(input logic [11:0] c, input int unsigned off,
			input logic [11:0] v);
		if (c[0]) begin
			table_copy[off]     = (table_copy[off] & LOW_NIBBLE) | {v[3:0], 4'h0};
			table_copy[off + 1] = v[11:4];
		end else begin
			table_copy[off]     = v[7:0];
			table_copy[off + 1] = (table_copy[off + 1] & HIGH_NIBBLE) | {4'h0, v[11:8]};
		end
	endfunction

	function automatic rsp_t resolve_request(input req_t r);
		rsp_t        res;
		int unsigned off;
		int unsigned count;
		logic [11:0] walk;
		logic [11:0] link;
		bit          walking;
		res   = '0;
		count = 0;
		off   = 0;
		case (r.operation)
			OP_WRITE_BYTE: begin
				if (r.byte_addr < TABLE_BYTES)
					table_copy[r.byte_addr] = r.byte_data;
				else
					res.error = 1'b1;
			end
			OP_READ_BYTE: begin
				if (r.byte_addr < TABLE_BYTES)
					res.read_value = {4'h0, table_copy[r.byte_addr]};
				else
					res.error = 1'b1;
			end
			OP_READ_ENTRY: begin
				if (r.cluster == 0)
					res.read_value = END_MARK;
				else if (locate_entry(r.cluster, off))
					res.read_value = fetch_entry(r.cluster, off);
				else
					res.error = 1'b1;
			end
			OP_WRITE_ENTRY: begin
				if (locate_entry(r.cluster, off))
					store_entry(r.cluster, off, r.entry_value);
				else
					res.error = 1'b1;
			end
			OP_FREE_CHAIN: begin
				walk    = r.cluster;
				walking = (walk != 0) && ((walk & END_MARK) != END_MARK);
				while (walking) begin
					if (count >= MAX_CLUSTERS || !locate_entry(walk, off)) begin
						res.error = 1'b1;
						walking   = 1'b0;
					end else begin
						// Take the link before the mark overwrites it
						link = fetch_entry(walk, off);
						store_entry(walk, off, mark_value);
						count++;
						walk    = link;
						walking = (walk != 0) && ((walk & END_MARK) != END_MARK);
					end
				end
				res.freed_count = 13'(count);
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_value = '0;
			due_responses.delete();
			waiting <= 0;
		end else begin
			if (free_mark_we)
				mark_value = free_mark_data;
			if (req_valid && !req_stall)
				due_responses.push_back(resolve_request(req));
			if (rsp_valid && !rsp_stall) begin
				if (due_responses.size() == 0) begin
					report_mismatch("unexpected response beat", {1'b0, rsp.read_value}, '0);
				end else begin
					oldest = due_responses.pop_front();
					if (rsp.read_value !== oldest.read_value)
						report_mismatch("read_value", {1'b0, rsp.read_value},
							{1'b0, oldest.read_value});
					if (rsp.freed_count !== oldest.freed_count)
						report_mismatch("freed_count", rsp.freed_count, oldest.freed_count);
					if (rsp.error !== oldest.error)
						report_mismatch("error", {12'h000, rsp.error}, {12'h000, oldest.error});
				end
			end
			waiting <= due_responses.size();
		end
	end

endmodule

>>> verif/tb_fat12_table_engine.sv
// Testbench top for the FAT12 table engine: clock, reset, request and response traffic.
`timescale 1ns / 1ps

module tb_fat12_table_engine import fat12_pkg::*;;

	localparam int TABLE_BYTES     = 6144;
	localparam int MAX_CLUSTERS    = 4096;
	localparam int LOW_BYTE_LAST   = 95;    // clusters 0..63
	localparam int HIGH_BYTE_FIRST = 6120;  // clusters 4080..4095
	localparam int STALL_LIMIT     = 100000;

	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req_beat = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp_beat;
	logic        free_mark_we = 1'b0;
	logic [11:0] free_mark_data = '0;

	int mismatches;
	int outstanding;
	int beats_sent = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b0;
	bit squeeze = 1'b0;
	bit squeeze_done = 1'b0;

	fat12_table_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req_beat),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp_beat),
		.free_mark_we   (free_mark_we),
		.free_mark_data (free_mark_data)
	);

	fat12_table_checker #(
		.TABLE_BYTES  (TABLE_BYTES),
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req_beat),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp_beat),
		.free_mark_we   (free_mark_we),
		.free_mark_data (free_mark_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || free_mark_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Response side: random stall bursts, plus one long hold-off to back up the engine
	initial begin
		forever begin
			@(posedge clk);
			if (squeeze && !squeeze_done) begin
				squeeze_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic req_t make_request(input logic [2:0] op, input logic [12:0] addr,
			input logic [7:0] data, input logic [11:0] cl, input logic [11:0] val);
		req_t beat;
		beat.operation   = op;
		beat.byte_addr   = addr;
		beat.byte_data   = data;
		beat.cluster     = cl;
		beat.entry_value = val;
		return beat;
	endfunction

	function automatic req_t random_request();
		return make_request(3'($urandom_range(0, 7)), 13'($urandom_range(0, 8191)),
			8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)));
	endfunction

	// Only the filled bytes may ever be read back
	function automatic logic [12:0] pick_written_byte();
		if ($urandom_range(0, 5) == 0)
			return 13'($urandom_range(HIGH_BYTE_FIRST, TABLE_BYTES - 1));
		return 13'($urandom_range(0, LOW_BYTE_LAST));
	endfunction

	function automatic logic [11:0] pick_written_cluster();
		if ($urandom_range(0, 5) == 0)
			return 12'($urandom_range(4080, 4095));
		return 12'($urandom_range(0, 63));
	endfunction

	// Clusters a walk may step on: not zero and not an end mark
	function automatic logic [11:0] pick_link_cluster();
		if ($urandom_range(0, 7) == 0)
			return 12'($urandom_range(4080, 4087));
		return 12'($urandom_range(1, 63));
	endfunction

	task automatic send_request(input req_t beat);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_beat  <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		beats_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_free_mark(input logic [11:0] mark);
		free_mark_we   <= 1'b1;
		free_mark_data <= mark;
		@(posedge clk);
		free_mark_we   <= 1'b0;
	endtask

	// Link distinct clusters into a fresh chain, then free it from its head or another of its links
	task automatic free_fresh_chain();
		logic [11:0] links [$];
		bit          taken [4096];
		logic [11:0] c;
		req_t        beat;
		int          len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
		while (links.size() < len) begin
			c = pick_link_cluster();
			if (!taken[c]) begin
				taken[c] = 1'b1;
				links.push_back(c);
			end
		end
		for (int i = 0; i < len; i++) begin
			beat = random_request();
			beat.operation = OP_WRITE_ENTRY;
			beat.cluster   = links[i];
			if (i < len - 1)
				beat.entry_value = links[i + 1];
			else if ($urandom_range(0, 1) == 0)
				beat.entry_value = 12'h000;
			else
				beat.entry_value = 12'($urandom_range(END_MARK, ENTRY_MASK));
			send_request(beat);
		end
		beat = random_request();
		beat.operation = OP_FREE_CHAIN;
		beat.cluster   = ($urandom_range(0, 4) == 0) ? links[$urandom_range(0, len - 1)] : links[0];
		send_request(beat);
	endtask

	task automatic loose_request();
		req_t beat;
		beat = random_request();
		case (beat.operation)
			OP_WRITE_BYTE: begin
				if ($urandom_range(0, 3) != 0)
					beat.byte_addr = pick_written_byte();
			end
			OP_READ_BYTE: begin
				if ($urandom_range(0, 5) == 0)
					beat.byte_addr = 13'($urandom_range(TABLE_BYTES, 8191));
				else
					beat.byte_addr = pick_written_byte();
			end
			OP_READ_ENTRY, OP_WRITE_ENTRY: beat.cluster = pick_written_cluster();
			OP_FREE_CHAIN: begin
				if ($urandom_range(0, 1) == 0)
					beat.cluster = 12'h000;
				else
					beat.cluster = 12'($urandom_range(END_MARK, ENTRY_MASK));
			end
			default: ;
		endcase
		send_request(beat);
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 1) == 0)
				free_fresh_chain();
			else
				loose_request();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;
		set_free_mark(ENTRY_MASK);

		// Fill both ends of the table before anything reads it
		for (int a = 0; a <= LOW_BYTE_LAST; a++)
			send_request(make_request(OP_WRITE_BYTE, 13'(a), 8'($urandom_range(0, 255)),
				12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))));
		for (int a = HIGH_BYTE_FIRST; a < TABLE_BYTES; a++)
			send_request(make_request(OP_WRITE_BYTE, 13'(a), 8'($urandom_range(0, 255)),
				12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))));

		send_request(make_request(OP_WRITE_BYTE, 13'd0, 8'h00, 12'h000, 12'h000));
		send_request(make_request(OP_WRITE_BYTE, 13'd6143, 8'hff, 12'hfff, 12'hfff));
		send_request(make_request(OP_READ_BYTE, 13'd0, 8'h00, 12'h000, 12'h000));
		send_request(make_request(OP_READ_BYTE, 13'd6143, 8'h00, 12'h000, 12'h000));
		send_request(make_request(OP_WRITE_BYTE, 13'd6144, 8'ha5, 12'h000, 12'h000));
		send_request(make_request(OP_READ_BYTE, 13'h1fff, 8'h00, 12'h000, 12'h000));
		send_request(make_request(OP_WRITE_BYTE, 13'h1fff, 8'h5a, 12'h000, 12'h000));
		send_request(make_request(OP_READ_ENTRY, 13'd0, 8'h00, 12'h000, 12'h000));
		send_request(make_request(OP_WRITE_ENTRY, 13'd0, 8'h00, 12'h000, 12'hfff));
		send_request(make_request(OP_WRITE_ENTRY, 13'd0, 8'h00, 12'h001, 12'h000));
		send_request(make_request(OP_READ_ENTRY, 13'd0, 8'h00, 12'h001, 12'h000));
		send_request(make_request(OP_WRITE_ENTRY, 13'd0, 8'h00, 12'hfff, 12'h0f0));
		send_request(make_request(OP_READ_ENTRY, 13'd0, 8'h00, 12'hfff, 12'h000));
		send_request(make_request(OP_READ_ENTRY, 13'd0, 8'h00, 12'hffe, 12'h000));
		send_request(make_request(OP_FREE_CHAIN, 13'd0, 8'h00, 12'h000, 12'h000));
		send_request(make_request(OP_FREE_CHAIN, 13'd0, 8'h00, END_MARK, 12'h000));
		send_request(make_request(OP_FREE_CHAIN, 13'd0, 8'h00, 12'hfff, 12'h000));
		send_request(make_request(OP_WRITE_ENTRY, 13'd0, 8'h00, 12'd2, 12'd3));
		send_request(make_request(OP_WRITE_ENTRY, 13'd0, 8'h00, 12'd3, 12'd4087));
		send_request(make_request(OP_WRITE_ENTRY, 13'd0, 8'h00, 12'd4087, 12'hffc));
		send_request(make_request(OP_FREE_CHAIN, 13'd0, 8'h00, 12'd2, 12'h000));
		send_request(make_request(OP_READ_ENTRY, 13'd0, 8'h00, 12'd3, 12'h000));
		send_request(make_request(OP_UNUSED_FIRST, 13'h1fff, 8'hff, 12'hfff, 12'hfff));
		send_request(make_request(OP_UNUSED_LAST, 13'h1fff, 8'hff, 12'hfff, 12'hfff));
		drain();

		// A self link with the mark equal to itself walks until the bound stops it
		set_free_mark(12'd9);
		send_request(make_request(OP_WRITE_ENTRY, 13'd0, 8'h00, 12'd9, 12'd9));
		send_request(make_request(OP_FREE_CHAIN, 13'd0, 8'h00, 12'd9, 12'h000));
		drain();

		set_free_mark(12'h000);
		random_phase(180);
		drain();

		set_free_mark(12'($urandom_range(1, 4094)));
		squeeze = 1'b1;
		random_phase(180);
		drain();

		set_free_mark(12'h800);
		random_phase(160);
		drain();

		gaps_on = 1'b0;
		set_free_mark(12'($urandom_range(0, 4095)));
		random_phase(160);
		drain();

		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
